// File: rtl/sdm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time functions for the steer and
// differential drive mixer. No dependencies.
package sdm_pkg;

    // Default sizing handed to the top level parameters
    localparam int TAN_ENTRIES_DEF = 256;
    localparam int PWM_SCALE_DEF   = 1023;

    // Fixed-point constants
    localparam int POWER_DEAD   = 1639;     // 0.05 in Q1.15
    localparam int SERVO_CENTER = 90;
    localparam int SERVO_MAX    = 180;
    localparam int ANGLE_MIN    = 18775;    // 0.01 rad, degrees in Q.15
    localparam int ANGLE_FLOOR  = 93874;    // 0.05 rad, degrees in Q.15
    localparam int SPAN_SHIFT   = 21;       // 64 degrees in Q.15
    localparam int ONE_Q12      = 4096;
    localparam int FACTOR_CAP   = 3686;     // 0.9 in Q0.12
    localparam int ONE_Q27      = 134217728;
    localparam int SERIES_TERMS = 12;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Widths
    localparam int ANGLE_W  = 21;           // |steer| * max degrees
    localparam int TAN_W    = 16;
    localparam int TG_W     = 24;           // track * gain
    localparam int PROD_W   = TG_W + TAN_W;
    localparam int NUM_SHIFT = 13;          // divide by 2 and drop Q12 fraction
    localparam int NUM_W    = PROD_W - NUM_SHIFT;
    localparam int DIV_BITS = 12;           // quotient bits, covers the cap
    localparam int REM_W    = 8 + DIV_BITS; // remainder stays below wheelbase << 12
    localparam int F_W      = 12;
    localparam int K_W      = 14;
    localparam int V_W      = 30;           // power * (1 +/- f), Q.27 signed
    localparam int MAG_W    = 28;
    localparam int DUTY_W   = 11;

    // Pipeline depth of each section
    localparam int FRONT_LAT = 4;
    localparam int DIV_LAT   = DIV_BITS + 3;
    localparam int DRIVE_LAT = 4;

    // Register map
    typedef enum logic [2:0] {
        REG_STEER_DZ  = 3'd0,
        REG_SERVO_OFS = 3'd1,
        REG_MAX_DEG   = 3'd2,
        REG_WHEELBASE = 3'd3,
        REG_TRACK     = 3'd4,
        REG_GAIN      = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [14:0] steer_dz;
        logic [5:0]  servo_ofs;     // signed degrees
        logic [5:0]  max_deg;
        logic [7:0]  wheelbase;
        logic [7:0]  track;
        logic [15:0] gain;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        steer_dz:  15'd3277,
        servo_ofs: 6'd0,
        max_deg:   6'd30,
        wheelbase: 8'd20,
        track:     8'd15,
        gain:      16'd4096
    };

    // Per-item side data that rides along the pipeline
    typedef struct packed {
        logic signed [15:0] power;      // after dead zone
        logic               steer_neg;
        logic               steer_nz;
        logic [7:0]         servo;
    } t_carry;

    // Shift-and-subtract quotient for the table math at elaboration
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        logic [64:0]     rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= 65'(den)) begin
                rem  = rem - 65'(den);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Taylor series in Q30: sine when odd is set, else cosine
    function automatic longint series_q30(input longint unsigned x, input bit odd);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned n;
        longint unsigned den;
        longint          sum;
        x2   = (x * x) >> 30;
        term = odd ? x : (64'd1 << 30);
        n    = odd ? 64'd1 : 64'd0;
        sum  = signed'(term);
        for (int j = 0; j < SERIES_TERMS; j++) begin
            den  = (n + 64'd1) * (n + 64'd2);
            term = udiv64((term * x2) >> 30, den);
            n    = n + 64'd2;
            if ((j & 1) == 1) begin
                sum = sum + signed'(term);
            end else begin
                sum = sum - signed'(term);
            end
        end
        return sum;
    endfunction

    // tan of entry idx over 0..64 degrees, Q4.12 truncated
    function automatic logic [TAN_W-1:0] tan_entry(input int unsigned idx,
                                                   input int unsigned entries);
        longint unsigned span;
        longint unsigned x;
        longint unsigned q;
        longint unsigned cu;
        longint          s;
        longint          c;
        span = 64'd180 * 64'(entries);
        x    = udiv64(64'(idx) * 64'd64 * PI_Q30, span);
        s    = series_q30(x, 1'b1);
        c    = series_q30(x, 1'b0);
        if (s < 0) begin
            s = 0;
        end
        if (c <= 0) begin
            q = 64'hFFFF;
        end else begin
            cu = unsigned'(c);
            q  = udiv64(unsigned'(s) << 12, cu);
        end
        return TAN_W'(q);
    endfunction

endpackage

// File: rtl/sdm_front.sv
`timescale 1ns / 1ps
// Front section: dead zones, steering angle, servo angle, tan table lookup.
// Depends on sdm_pkg.
module sdm_front #(
    parameter int P_TAN_ENTRIES = sdm_pkg::TAN_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sdm_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    input  logic signed [15:0]            i_power,
    input  logic signed [15:0]            i_steer,
    output logic                          o_valid,
    output logic [sdm_pkg::TAN_W-1:0]     o_tan,
    output sdm_pkg::t_carry               o_carry
);
    import sdm_pkg::*;

    localparam int IDX_W  = $clog2(P_TAN_ENTRIES);
    localparam int SPAN_W = ANGLE_W + $clog2(P_TAN_ENTRIES + 1);

    // Constant tan table
    logic [TAN_W-1:0] w_rom [P_TAN_ENTRIES];

    for (genvar gi = 0; gi < P_TAN_ENTRIES; gi++) begin : g_rom
        localparam logic [TAN_W-1:0] TAN_VAL = tan_entry(gi, P_TAN_ENTRIES);
        assign w_rom[gi] = TAN_VAL;
    end

    // Stage 1: magnitudes and dead zones
    logic signed [16:0] w_steer_x;
    logic signed [16:0] w_power_x;
    logic [16:0]        w_smag;
    logic [16:0]        w_pmag;
    logic               w_steer_live;
    logic               w_power_live;
    t_carry             w_c1;

    assign w_steer_x = 17'(i_steer);
    assign w_power_x = 17'(i_power);
    assign w_smag = w_steer_x[16] ? unsigned'(-w_steer_x) : unsigned'(w_steer_x);
    assign w_pmag = w_power_x[16] ? unsigned'(-w_power_x) : unsigned'(w_power_x);
    assign w_steer_live = (w_smag >= 17'(i_cfg.steer_dz));
    assign w_power_live = (w_pmag >= 17'(POWER_DEAD));

    always_comb begin
        w_c1.power     = w_power_live ? i_power : 16'sd0;
        w_c1.steer_nz  = w_steer_live && (w_smag != 17'd0);
        w_c1.steer_neg = w_c1.steer_nz && i_steer[15];
        w_c1.servo     = 8'd0;
    end

    logic        r1_valid;
    logic [15:0] r1_smag;
    t_carry      r1_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_smag  <= w_steer_live ? w_smag[15:0] : 16'd0;
        r1_carry <= w_c1;
    end

    // Stage 2: steering angle in Q.15 degrees
    logic [ANGLE_W-1:0] w_d;
    logic               r2_valid;
    logic [ANGLE_W-1:0] r2_d;
    t_carry             r2_carry;

    assign w_d = ANGLE_W'(r1_smag) * ANGLE_W'(i_cfg.max_deg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_d     <= w_d;
        r2_carry <= r1_carry;
    end

    // Stage 3: servo angle and table index
    logic signed [9:0]  w_q;
    logic signed [9:0]  w_ofs;
    logic signed [9:0]  w_ang;
    logic [7:0]         w_servo;
    logic [ANGLE_W-1:0] w_dfl;
    logic [SPAN_W-1:0]  w_span;
    logic [SPAN_W-1:0]  w_idx_full;
    logic [IDX_W-1:0]   w_idx;
    t_carry             w_c3;

    assign w_q   = $signed(10'(r2_d[ANGLE_W-1:15]));
    assign w_ofs = 10'($signed(i_cfg.servo_ofs));
    assign w_ang = 10'(SERVO_CENTER) + w_ofs + (r2_carry.steer_neg ? -w_q : w_q);

    always_comb begin
        if (w_ang < 10'sd0) begin
            w_servo = 8'd0;
        end else if (w_ang > 10'(SERVO_MAX)) begin
            w_servo = 8'(SERVO_MAX);
        end else begin
            w_servo = w_ang[7:0];
        end
    end

    // Floor tiny angles, then scale to a table index
    assign w_dfl      = (r2_d < ANGLE_W'(ANGLE_MIN)) ? ANGLE_W'(ANGLE_FLOOR) : r2_d;
    assign w_span     = SPAN_W'(w_dfl) * SPAN_W'(P_TAN_ENTRIES);
    assign w_idx_full = w_span >> SPAN_SHIFT;
    assign w_idx      = (w_idx_full >= SPAN_W'(P_TAN_ENTRIES))
                        ? IDX_W'(P_TAN_ENTRIES - 1) : IDX_W'(w_idx_full);

    always_comb begin
        w_c3       = r2_carry;
        w_c3.servo = w_servo;
    end

    logic             r3_valid;
    logic [IDX_W-1:0] r3_idx;
    t_carry           r3_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_idx   <= w_idx;
        r3_carry <= w_c3;
    end

    // Stage 4: table read
    logic             r4_valid;
    logic [TAN_W-1:0] r4_tan;
    t_carry           r4_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_tan   <= w_rom[r3_idx];
        r4_carry <= r3_carry;
    end

    assign o_valid = r4_valid;
    assign o_tan   = r4_tan;
    assign o_carry = r4_carry;

endmodule

// File: rtl/sdm_div.sv
`timescale 1ns / 1ps
// Differential factor: track*gain*tan / (2*wheelbase) in Q0.12, capped,
// through a one-bit-per-stage pipelined divider. Depends on sdm_pkg.
module sdm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sdm_pkg::t_cfg             i_cfg,
    input  logic                      i_valid,
    input  logic [sdm_pkg::TAN_W-1:0] i_tan,
    input  sdm_pkg::t_carry           i_carry,
    output logic                      o_valid,
    output logic [sdm_pkg::F_W-1:0]   o_f,
    output sdm_pkg::t_carry           o_carry
);
    import sdm_pkg::*;

    // Track times gain changes only when the configuration registers change
    logic [TG_W-1:0] r_tg;

    always_ff @(posedge i_clk) begin
        r_tg <= TG_W'(i_cfg.track) * TG_W'(i_cfg.gain);
    end

    // Numerator product
    logic              r_m1_valid;
    logic [PROD_W-1:0] r_prod;
    t_carry            r_m1_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else begin
            r_m1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= PROD_W'(r_tg) * PROD_W'(i_tan);
        r_m1_carry <= i_carry;
    end

    // Overflow check: quotient at or above 4096 is past the cap anyway
    logic [NUM_W-1:0] w_num;
    logic [NUM_W-1:0] w_lim;
    logic             w_ovf;

    assign w_num = r_prod[PROD_W-1:NUM_SHIFT];
    assign w_lim = NUM_W'(i_cfg.wheelbase) << DIV_BITS;
    assign w_ovf = (i_cfg.wheelbase == 8'd0) || (w_num >= w_lim);

    // Divider stages: entry 0 is the loaded numerator, entry k after k bits
    logic                r_vld [0:DIV_BITS];
    logic [REM_W-1:0]    r_rem [0:DIV_BITS];
    logic [DIV_BITS-1:0] r_q   [0:DIV_BITS];
    logic                r_ovf [0:DIV_BITS];
    t_carry              r_cry [0:DIV_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= REM_W'(w_num);
        r_q[0]   <= '0;
        r_ovf[0] <= w_ovf;
        r_cry[0] <= r_m1_carry;
    end

    for (genvar gs = 1; gs <= DIV_BITS; gs++) begin : g_stage
        localparam int BIT = DIV_BITS - gs;

        logic [REM_W-1:0]    w_trial;
        logic                w_take;
        logic [DIV_BITS-1:0] w_qn;

        assign w_trial = REM_W'(i_cfg.wheelbase) << BIT;
        assign w_take  = (r_rem[gs-1] >= w_trial);

        always_comb begin
            w_qn      = r_q[gs-1];
            w_qn[BIT] = w_take;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gs] <= 1'b0;
            end else begin
                r_vld[gs] <= r_vld[gs-1];
            end
        end

        // Subtract the shifted divisor where it fits
        always_ff @(posedge i_clk) begin
            r_rem[gs] <= w_take ? (r_rem[gs-1] - w_trial) : r_rem[gs-1];
            r_q[gs]   <= w_qn;
            r_ovf[gs] <= r_ovf[gs-1];
            r_cry[gs] <= r_cry[gs-1];
        end
    end

    // Cap the factor; straight driving uses no factor
    logic [F_W-1:0] w_f;
    logic           r_f_valid;
    logic [F_W-1:0] r_f;
    t_carry         r_f_carry;

    always_comb begin
        if (!r_cry[DIV_BITS].steer_nz) begin
            w_f = '0;
        end else if (r_ovf[DIV_BITS] || (r_q[DIV_BITS] > DIV_BITS'(FACTOR_CAP))) begin
            w_f = F_W'(FACTOR_CAP);
        end else begin
            w_f = F_W'(r_q[DIV_BITS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= r_vld[DIV_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f       <= w_f;
        r_f_carry <= r_cry[DIV_BITS];
    end

    assign o_valid = r_f_valid;
    assign o_f     = r_f;
    assign o_carry = r_f_carry;

endmodule

// File: rtl/sdm_drive.sv
`timescale 1ns / 1ps
// Drive section: inner and outer wheel speeds, clamp, duty scaling, side
// choice and the output register. Depends on sdm_pkg.
module sdm_drive #(
    parameter int P_PWM_SCALE = sdm_pkg::PWM_SCALE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [sdm_pkg::F_W-1:0]      i_f,
    input  sdm_pkg::t_carry              i_carry,
    output logic                         o_valid,
    output logic [7:0]                   o_servo_angle,
    output logic signed [sdm_pkg::DUTY_W-1:0] o_left_pwm,
    output logic signed [sdm_pkg::DUTY_W-1:0] o_right_pwm
);
    import sdm_pkg::*;

    localparam int PW   = $clog2(P_PWM_SCALE + 1);
    localparam int SP_W = MAG_W + PW;
    localparam int DW   = (PW + 1 > DUTY_W) ? PW + 1 : DUTY_W;

    // Clamp a Q.27 speed to +-1.0 and return its magnitude
    function automatic logic [MAG_W-1:0] clamp_mag(input logic signed [V_W-1:0] v);
        logic [V_W-1:0] a;
        a = v[V_W-1] ? unsigned'(-v) : unsigned'(v);
        if (a > V_W'(ONE_Q27)) begin
            a = V_W'(ONE_Q27);
        end
        return MAG_W'(a);
    endfunction

    // Stage 1: speeds power * (1 - f) and power * (1 + f)
    logic [K_W-1:0]        w_k_in;
    logic [K_W-1:0]        w_k_out;
    logic signed [V_W-1:0] w_v_in;
    logic signed [V_W-1:0] w_v_out;

    assign w_k_in  = K_W'(ONE_Q12) - K_W'(i_f);
    assign w_k_out = K_W'(ONE_Q12) + K_W'(i_f);
    assign w_v_in  = V_W'(i_carry.power) * $signed(V_W'(w_k_in));
    assign w_v_out = V_W'(i_carry.power) * $signed(V_W'(w_k_out));

    logic                  r1_valid;
    logic signed [V_W-1:0] r1_v_in;
    logic signed [V_W-1:0] r1_v_out;
    logic                  r1_neg;
    logic [7:0]            r1_servo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_v_in  <= w_v_in;
        r1_v_out <= w_v_out;
        r1_neg   <= i_carry.steer_neg;
        r1_servo <= i_carry.servo;
    end

    // Stage 2: clamp and split into sign and magnitude
    logic             r2_valid;
    logic [MAG_W-1:0] r2_mag_in;
    logic [MAG_W-1:0] r2_mag_out;
    logic             r2_sgn;
    logic             r2_neg;
    logic [7:0]       r2_servo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    // Both speeds share the sign of power
    always_ff @(posedge i_clk) begin
        r2_mag_in  <= clamp_mag(r1_v_in);
        r2_mag_out <= clamp_mag(r1_v_out);
        r2_sgn     <= r1_v_in[V_W-1] | r1_v_out[V_W-1];
        r2_neg     <= r1_neg;
        r2_servo   <= r1_servo;
    end

    // Stage 3: scale to full-scale duty
    logic            r3_valid;
    logic [SP_W-1:0] r3_p_in;
    logic [SP_W-1:0] r3_p_out;
    logic            r3_sgn;
    logic            r3_neg;
    logic [7:0]      r3_servo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_p_in  <= SP_W'(r2_mag_in) * SP_W'(P_PWM_SCALE);
        r3_p_out <= SP_W'(r2_mag_out) * SP_W'(P_PWM_SCALE);
        r3_sgn   <= r2_sgn;
        r3_neg   <= r2_neg;
        r3_servo <= r2_servo;
    end

    // Stage 4: drop the fraction, restore sign, pick sides
    logic [PW-1:0]        w_dm_in;
    logic [PW-1:0]        w_dm_out;
    logic signed [DW-1:0] w_sd_in;
    logic signed [DW-1:0] w_sd_out;
    logic [DUTY_W-1:0]    w_inner;
    logic [DUTY_W-1:0]    w_outer;

    assign w_dm_in  = PW'(r3_p_in >> (MAG_W - 1));
    assign w_dm_out = PW'(r3_p_out >> (MAG_W - 1));
    assign w_sd_in  = r3_sgn ? -$signed(DW'(w_dm_in)) : $signed(DW'(w_dm_in));
    assign w_sd_out = r3_sgn ? -$signed(DW'(w_dm_out)) : $signed(DW'(w_dm_out));
    assign w_inner  = w_sd_in[DUTY_W-1:0];
    assign w_outer  = w_sd_out[DUTY_W-1:0];

    logic                     r4_valid;
    logic [7:0]               r4_servo;
    logic signed [DUTY_W-1:0] r4_left;
    logic signed [DUTY_W-1:0] r4_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    // Turning left puts the inner speed on the left wheel
    always_ff @(posedge i_clk) begin
        r4_servo <= r3_servo;
        r4_left  <= $signed(r3_neg ? w_inner : w_outer);
        r4_right <= $signed(r3_neg ? w_outer : w_inner);
    end

    assign o_valid       = r4_valid;
    assign o_servo_angle = r4_servo;
    assign o_left_pwm    = r4_left;
    assign o_right_pwm   = r4_right;

endmodule

// File: rtl/steer_and_differential_drive_mixer_core.sv
`timescale 1ns / 1ps
// Top level of the steer and differential drive mixer: register file and
// the front, divider and drive sections. Depends on sdm_pkg, sdm_front,
// sdm_div and sdm_drive.
//
//   channel   handshake                    payload
//   command   i_start / o_busy             i_power, i_steer
//   result    o_valid (strobe, one cycle)  o_servo_angle, o_left_pwm, o_right_pwm
//   config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One command enters per clock. The pipeline depth is set by the twelve-stage
// restoring divider for the factor, with its product, load and cap registers,
// plus the front and drive stages.
// o_busy and o_cfg_ready follow the synchronous reset only; reset loads the
// register defaults and empties the pipeline. Results cannot be stalled.
module steer_and_differential_drive_mixer_core #(
    parameter int P_TAN_ENTRIES = sdm_pkg::TAN_ENTRIES_DEF,
    parameter int P_PWM_SCALE   = sdm_pkg::PWM_SCALE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [15:0]                 i_power,
    input  logic signed [15:0]                 i_steer,
    output logic                               o_valid,
    output logic [7:0]                         o_servo_angle,
    output logic signed [sdm_pkg::DUTY_W-1:0]  o_left_pwm,
    output logic signed [sdm_pkg::DUTY_W-1:0]  o_right_pwm,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [2:0]                         i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);
    import sdm_pkg::*;

    localparam int LATENCY = FRONT_LAT + DIV_LAT + DRIVE_LAT;

    logic w_accept;
    logic w_cfg_we;

    assign o_busy      = !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_accept    = i_start && !o_busy;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // Configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (w_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_STEER_DZ:  r_cfg.steer_dz  <= i_cfg_data[14:0];
                REG_SERVO_OFS: r_cfg.servo_ofs <= i_cfg_data[5:0];
                REG_MAX_DEG:   r_cfg.max_deg   <= i_cfg_data[5:0];
                REG_WHEELBASE: r_cfg.wheelbase <= i_cfg_data[7:0];
                REG_TRACK:     r_cfg.track     <= i_cfg_data[7:0];
                REG_GAIN:      r_cfg.gain      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: dead zones, servo, table lookup
    logic             w_fr_valid;
    logic [TAN_W-1:0] w_fr_tan;
    t_carry           w_fr_carry;

    sdm_front #(
        .P_TAN_ENTRIES (P_TAN_ENTRIES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_accept),
        .i_power (i_power),
        .i_steer (i_steer),
        .o_valid (w_fr_valid),
        .o_tan   (w_fr_tan),
        .o_carry (w_fr_carry)
    );

    // Differential factor
    logic           w_dv_valid;
    logic [F_W-1:0] w_dv_f;
    t_carry         w_dv_carry;

    sdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_fr_valid),
        .i_tan   (w_fr_tan),
        .i_carry (w_fr_carry),
        .o_valid (w_dv_valid),
        .o_f     (w_dv_f),
        .o_carry (w_dv_carry)
    );

    // Wheel duties and output register
    sdm_drive #(
        .P_PWM_SCALE (P_PWM_SCALE)
    ) u_drive (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_dv_valid),
        .i_f           (w_dv_f),
        .i_carry       (w_dv_carry),
        .o_valid       (o_valid),
        .o_servo_angle (o_servo_angle),
        .o_left_pwm    (o_left_pwm),
        .o_right_pwm   (o_right_pwm)
    );

    // Every transfer in produces exactly one strobe after the fixed latency
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid)
        else $error("accepted command produced no result");

    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result strobe without a matching command");

    a_servo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_servo_angle <= 8'(SERVO_MAX)))
        else $error("servo angle past saturation limit");

endmodule
